// File: rtl/core/sm4_block_cipher_ecb_cbc_unit_assert.svh
// assertion helpers for the sm4 cipher unit
`ifndef SM4_BLOCK_CIPHER_ECB_CBC_UNIT_ASSERT_SVH
`define SM4_BLOCK_CIPHER_ECB_CBC_UNIT_ASSERT_SVH

// same-cycle implication
`define SM4_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SM4_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/sm4_pkg.sv
`default_nettype none
package sm4_pkg;

	localparam int ROUNDS = 32;
	localparam int RK_AW = $clog2(ROUNDS);
	localparam int CFG_IW = 3;
	localparam logic [127:0] FK_ALL = 128'hA3B1BAC6_56AA3350_677D9197_B27022DC;

	localparam logic [CFG_IW-1:0] CFG_KEY_HIGH = 3'd0;
	localparam logic [CFG_IW-1:0] CFG_KEY_LOW = 3'd1;
	localparam logic [CFG_IW-1:0] CFG_IV_HIGH = 3'd2;
	localparam logic [CFG_IW-1:0] CFG_IV_LOW = 3'd3;
	localparam logic [CFG_IW-1:0] CFG_DECRYPT = 3'd4;
	localparam logic [CFG_IW-1:0] CFG_CBC = 3'd5;
	localparam logic [CFG_IW-1:0] CFG_IV_PRESENT = 3'd6;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_KEXP,
		ST_PREP,
		ST_ROUND,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic             we;
		logic [RK_AW-1:0] waddr;
		logic [RK_AW-1:0] raddr;
	} rk_ctrl_t;

	localparam logic [7:0] SBOX [256] = '{
		8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
		8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
		8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
		8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
		8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
		8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
		8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
		8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
		8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
		8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
		8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
		8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
		8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
		8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
		8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
		8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
	};

	function automatic logic [31:0] rotl32(input logic [31:0] x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	// byte j of ck word i is (4i+j)*7 mod 256
	function automatic logic [31:0] ck_word(input logic [RK_AW-1:0] i);
		logic [31:0] w;
		logic [9:0]  p;
		w = '0;
		for (int j = 0; j < 4; j++) begin
			p = {1'b0, i, 2'(j), 2'b00} >> 2;
			p = p * 10'd7;
			w = {w[23:0], p[7:0]};
		end
		return w;
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/sm4_block_cipher_ecb_cbc_unit.sv
// channel   | direction | beat fields
// s_t*      | in        | tdata: block_high, block_low; tuser: first_block
// m_t*      | out       | tdata: result_high, result_low
// cfg_*     | in        | cfg_index, cfg_data (write only, always ready)
//
// one block goes from accept through load, the rounds and finish to its result
// a first block adds key expansion through the same round unit; with cbc decrypt and no iv it only seeds the chain
// key expansion and the rounds share the single round unit and the round key ram
// s_tready is high only while idle; a finished result waits in the output register
// arst_n clears control and chaining state; round keys hold garbage until expanded
`default_nettype none
`include "sm4_block_cipher_ecb_cbc_unit_assert.svh"
module sm4_block_cipher_ecb_cbc_unit
	import sm4_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [127:0]      s_tdata,  // block_high, block_low
	input  wire logic              s_tuser,  // first_block
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [127:0]           m_tdata,  // result_high, result_low
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [CFG_IW-1:0] cfg_index,
	input  wire logic [63:0]       cfg_data
);

	state_t state_q, state_d;

	logic [127:0]     key_q, iv_q;
	logic             dec_q, cbc_q, ivp_q;
	logic [127:0]     cv_q;
	logic [127:0]     w_q;
	logic [127:0]     blk_q;
	logic [RK_AW-1:0] cnt_q;
	logic             seed_q;
	logic             m_tvalid_q;
	logic [127:0]     m_tdata_q;

	logic             accept;
	logic             out_load;
	logic             last_cnt;
	logic [127:0]     blk_in;
	logic [127:0]     raw;
	logic [31:0]      rk_rd;
	logic [31:0]      rk_sel;
	logic [31:0]      nx;
	logic [RK_AW-1:0] next_idx;
	rk_ctrl_t         rk_ctrl;

	assign cfg_ready = 1'b1;
	assign s_tready = (state_q == ST_IDLE);
	assign accept = s_tvalid && s_tready;
	assign last_cnt = (cnt_q == RK_AW'(ROUNDS - 1));
	assign out_load = (state_q == ST_FIN) && (!m_tvalid_q || m_tready);
	assign blk_in = {s_tdata[63:0], s_tdata[127:64]};
	// words come out in reverse order
	assign raw = {w_q[31:0], w_q[63:32], w_q[95:64], w_q[127:96]};
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
			iv_q <= '0;
			dec_q <= 1'b0;
			cbc_q <= 1'b0;
			ivp_q <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_KEY_HIGH:   key_q[127:64] <= cfg_data;
				CFG_KEY_LOW:    key_q[63:0] <= cfg_data;
				CFG_IV_HIGH:    iv_q[127:64] <= cfg_data;
				CFG_IV_LOW:     iv_q[63:0] <= cfg_data;
				CFG_DECRYPT:    dec_q <= cfg_data[0];
				CFG_CBC:        cbc_q <= cfg_data[0];
				CFG_IV_PRESENT: ivp_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		next_idx = '0;
		rk_ctrl.we = 1'b0;
		rk_ctrl.waddr = cnt_q;
		rk_sel = rk_rd;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = s_tuser ? ST_KEXP : ST_PREP;
				end
			end
			ST_KEXP: begin
				rk_ctrl.we = 1'b1;
				rk_sel = ck_word(cnt_q);
				if (last_cnt) begin
					state_d = seed_q ? ST_IDLE : ST_PREP;
				end
			end
			ST_PREP: begin
				state_d = ST_ROUND;
			end
			ST_ROUND: begin
				next_idx = cnt_q + RK_AW'(1);
				if (last_cnt) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		// decryption walks the keys from the top down
		rk_ctrl.raddr = dec_q ? ~next_idx : next_idx;
	end

	sm4_rkmem u_rkmem (
		.clk   (clk),
		.ctrl  (rk_ctrl),
		.wdata (nx),
		.rdata (rk_rd)
	);

	sm4_round u_round (
		.w        (w_q),
		.rk       (rk_sel),
		.key_mode (state_q == ST_KEXP),
		.nx       (nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			seed_q <= 1'b0;
			cv_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == ST_KEXP || state_q == ST_ROUND) begin
				cnt_q <= cnt_q + RK_AW'(1);
			end else begin
				cnt_q <= '0;
			end
			if (accept) begin
				seed_q <= s_tuser && cbc_q && dec_q && !ivp_q;
				if (s_tuser) begin
					cv_q <= (cbc_q && dec_q && !ivp_q) ? blk_in : iv_q;
				end
			end
			if (out_load && cbc_q) begin
				cv_q <= dec_q ? blk_q : raw;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			blk_q <= blk_in;
			if (s_tuser) begin
				w_q <= key_q ^ FK_ALL;
			end
		end
		if (state_q == ST_KEXP || state_q == ST_ROUND) begin
			w_q <= {w_q[95:0], nx};
		end
		if (state_q == ST_PREP) begin
			w_q <= blk_q ^ ((cbc_q && !dec_q) ? cv_q : 128'd0);
		end
		if (out_load) begin
			if (cbc_q && dec_q) begin
				m_tdata_q <= {raw[63:0] ^ cv_q[63:0], raw[127:64] ^ cv_q[127:64]};
			end else begin
				m_tdata_q <= {raw[63:0], raw[127:64]};
			end
		end
	end

	`SM4_ASSERT_IMPL(a_out_from_fin, $rose(m_tvalid_q), $past(state_q) == ST_FIN, "result not from finish")
	`SM4_ASSERT_NEXT(a_prep_starts_rounds, state_q == ST_PREP, (state_q == ST_ROUND) && (cnt_q == '0), "rounds did not start at zero")
	`SM4_ASSERT_NEXT(a_kexp_exit, (state_q == ST_KEXP) && last_cnt, (state_q == ST_PREP) || (state_q == ST_IDLE), "bad exit from key expansion")

endmodule
`default_nettype wire

// File: rtl/core/sm4_round.sv
`default_nettype none
module sm4_round
	import sm4_pkg::*;
(
	input  wire logic [127:0] w,
	input  wire logic [31:0]  rk,
	input  wire logic         key_mode,
	output logic [31:0]       nx
);

	logic [31:0] a;
	logic [31:0] t;
	logic [31:0] lin;

	always_comb begin
		a = w[95:64] ^ w[63:32] ^ w[31:0] ^ rk;
		for (int b = 0; b < 4; b++) begin
			t[8*b +: 8] = SBOX[a[8*b +: 8]];
		end
		// key schedule uses the lighter transform
		if (key_mode) begin
			lin = t ^ rotl32(t, 13) ^ rotl32(t, 23);
		end else begin
			lin = t ^ rotl32(t, 2) ^ rotl32(t, 10) ^ rotl32(t, 18) ^ rotl32(t, 24);
		end
		nx = w[127:96] ^ lin;
	end

endmodule
`default_nettype wire

// File: rtl/core/sm4_rkmem.sv
`default_nettype none
module sm4_rkmem
	import sm4_pkg::*;
(
	input  wire logic        clk,
	input  wire rk_ctrl_t    ctrl,
	input  wire logic [31:0] wdata,
	output logic [31:0]      rdata
);

	logic [31:0] mem [ROUNDS];

	always_ff @(posedge clk) begin
		if (ctrl.we) begin
			mem[ctrl.waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[ctrl.raddr];
	end

endmodule
`default_nettype wire
